@@ design/gcf_pkg.sv @@
`default_nettype none

package gcf_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;

    localparam int PIX_W  = 8;
    localparam int SIZE_W = 11;
    localparam int KROW_W = 24;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int MIN_SIZE = 3;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd4;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd4;
    localparam logic [KROW_W-1:0] KROW_TOP_RESET    = 24'h00FF00;
    localparam logic [KROW_W-1:0] KROW_MIDDLE_RESET = 24'hFF04FF;
    localparam logic [KROW_W-1:0] KROW_BOTTOM_RESET = 24'h00FF00;

    // gray = (r+g+b)/3 as (sum * 683) >> 11, exact for sums up to 765
    localparam int GSUM_W     = 10;
    localparam int GPROD_W    = 20;
    localparam int GRAY_MUL   = 683;
    localparam int GRAY_SHIFT = 11;

    localparam int PROD_W = 17;
    localparam int ROW_W  = PROD_W + 2;
    localparam int TOT_W  = ROW_W + 2;
    localparam int PIX_MAX = 255;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [KROW_W-1:0] kernel_row_top;
        logic [KROW_W-1:0] kernel_row_middle;
        logic [KROW_W-1:0] kernel_row_bottom;
    } cfg_t;

    // [row][col] gray window, row 0 is the oldest line, col 0 the oldest column
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    function automatic logic signed [PIX_W-1:0] coef(input logic [KROW_W-1:0] row_bits,
                                                     input int col);
        return signed'(row_bits[PIX_W*col +: PIX_W]);
    endfunction

endpackage

`default_nettype wire

@@ design/gcf_pix_if.sv @@
`default_nettype none

interface gcf_pix_if;
    logic                       valid;
    logic                       ready;
    logic [gcf_pkg::PIX_W-1:0]  red;
    logic [gcf_pkg::PIX_W-1:0]  green;
    logic [gcf_pkg::PIX_W-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ design/gcf_res_if.sv @@
`default_nettype none

interface gcf_res_if;
    logic                       valid;
    logic                       ready;
    logic [gcf_pkg::PIX_W-1:0]  filtered_pixel;
    logic                       last_result;

    modport source (output valid, filtered_pixel, last_result, input ready);
    modport sink   (input valid, filtered_pixel, last_result, output ready);
endinterface

`default_nettype wire

@@ design/gcf_ram.sv @@
`default_nettype none

module gcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/gcf_regs.sv @@
`default_nettype none

module gcf_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gcf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gcf_pkg::DATA_W-1:0]    pwdata,
    output logic      [gcf_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output gcf_pkg::cfg_t                      cfg
);

    gcf_pkg::cfg_t     cfg_reg;
    gcf_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = gcf_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width       <= gcf_pkg::WIDTH_RESET;
            cfg_reg.image_height      <= gcf_pkg::HEIGHT_RESET;
            cfg_reg.kernel_row_top    <= gcf_pkg::KROW_TOP_RESET;
            cfg_reg.kernel_row_middle <= gcf_pkg::KROW_MIDDLE_RESET;
            cfg_reg.kernel_row_bottom <= gcf_pkg::KROW_BOTTOM_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                gcf_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= pwdata[gcf_pkg::SIZE_W-1:0];
                gcf_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= pwdata[gcf_pkg::SIZE_W-1:0];
                gcf_pkg::REG_KERNEL_TOP:
                    cfg_reg.kernel_row_top <= pwdata[gcf_pkg::KROW_W-1:0];
                gcf_pkg::REG_KERNEL_MIDDLE:
                    cfg_reg.kernel_row_middle <= pwdata[gcf_pkg::KROW_W-1:0];
                gcf_pkg::REG_KERNEL_BOTTOM:
                    cfg_reg.kernel_row_bottom <= pwdata[gcf_pkg::KROW_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            gcf_pkg::REG_IMAGE_WIDTH:   prdata = gcf_pkg::DATA_W'(cfg_reg.image_width);
            gcf_pkg::REG_IMAGE_HEIGHT:  prdata = gcf_pkg::DATA_W'(cfg_reg.image_height);
            gcf_pkg::REG_KERNEL_TOP:    prdata = gcf_pkg::DATA_W'(cfg_reg.kernel_row_top);
            gcf_pkg::REG_KERNEL_MIDDLE: prdata = gcf_pkg::DATA_W'(cfg_reg.kernel_row_middle);
            gcf_pkg::REG_KERNEL_BOTTOM: prdata = gcf_pkg::DATA_W'(cfg_reg.kernel_row_bottom);
            default:                    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/gcf_window.sv @@
`default_nettype none

module gcf_window #(
    parameter int MAX_WIDTH  = gcf_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = gcf_pkg::MAX_HEIGHT_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  gcf_pkg::cfg_t                   cfg,
    input  wire logic                       adv,
    input  wire logic                       in_acc,
    input  wire logic [gcf_pkg::PIX_W-1:0]  red,
    input  wire logic [gcf_pkg::PIX_W-1:0]  green,
    input  wire logic [gcf_pkg::PIX_W-1:0]  blue,
    output gcf_pkg::win_t                   win,
    output logic                            win_vld,
    output logic                            win_last
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int CH = $clog2(MAX_HEIGHT + 1);
    localparam int PW = gcf_pkg::PIX_W;
    localparam int LW = 2 * gcf_pkg::PIX_W;

    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [CW-1:0] w_eff, x, x1;
    logic [CH-1:0] h_eff, y_pre, y, y1;
    logic          emit, last;

    logic [gcf_pkg::GSUM_W-1:0]  gsum;
    logic [gcf_pkg::GPROD_W-1:0] gprod;
    logic [PW-1:0]               gray;

    logic          s1_vld_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic [XW-1:0] s1_x_reg;
    logic [PW-1:0] s1_gray_reg;

    logic [LW-1:0] line_rd;
    logic [LW-1:0] line_wr;

    gcf_pkg::win_t win_reg;
    logic          s2_vld_reg;
    logic          s2_last_reg;

    always_comb
    begin
        if (cfg.image_width < gcf_pkg::SIZE_W'(gcf_pkg::MIN_SIZE))
            w_eff = CW'(gcf_pkg::MIN_SIZE);
        else if (32'(cfg.image_width) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(cfg.image_width);

        if (cfg.image_height < gcf_pkg::SIZE_W'(gcf_pkg::MIN_SIZE))
            h_eff = CH'(gcf_pkg::MIN_SIZE);
        else if (32'(cfg.image_height) > MAX_HEIGHT)
            h_eff = CH'(MAX_HEIGHT);
        else
            h_eff = CH'(cfg.image_height);
    end

    // position of the arriving pixel; wraps if the size shrank since the last image
    always_comb
    begin
        if (CW'(col_reg) >= w_eff)
        begin
            x     = '0;
            y_pre = CH'(row_reg) + CH'(1);
        end
        else
        begin
            x     = CW'(col_reg);
            y_pre = CH'(row_reg);
        end
        y  = (y_pre >= h_eff) ? '0 : y_pre;
        x1 = x + CW'(1);
        y1 = y + CH'(1);
        if (x1 >= w_eff)
        begin
            col_next = '0;
            row_next = (y1 >= h_eff) ? '0 : YW'(y1);
        end
        else
        begin
            col_next = XW'(x1);
            row_next = YW'(y);
        end
        emit = (x >= CW'(2)) && (y >= CH'(2));
        last = (x == w_eff - CW'(1)) && (y == h_eff - CH'(1));
    end

    assign gsum  = gcf_pkg::GSUM_W'(red) + gcf_pkg::GSUM_W'(green) + gcf_pkg::GSUM_W'(blue);
    assign gprod = gcf_pkg::GPROD_W'(gsum) * gcf_pkg::GPROD_W'(gcf_pkg::GRAY_MUL);
    assign gray  = PW'(gprod >> gcf_pkg::GRAY_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_acc;
            s2_vld_reg <= s1_vld_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_x_reg    <= XW'(x);
            s1_gray_reg <= gray;
        end
        if (adv && s1_vld_reg)
        begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // one entry holds {older, newer} for a column. Same column comes back only
    // after at least three items, so the write-back never races its own read.
    gcf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (adv && s1_vld_reg),
        .waddr (s1_x_reg),
        .wdata (line_wr),
        .re    (in_acc),
        .raddr (XW'(x)),
        .rdata (line_rd)
    );

    assign line_wr = {line_rd[PW-1:0], s1_gray_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (adv && s1_vld_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= line_rd[LW-1:PW];
            win_reg[1][2] <= line_rd[PW-1:0];
            win_reg[2][2] <= s1_gray_reg;
        end
    end

    assign win      = win_reg;
    assign win_vld  = s2_vld_reg;
    assign win_last = s2_last_reg;

endmodule

`default_nettype wire

@@ design/gcf_mac.sv @@
`default_nettype none

module gcf_mac (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  gcf_pkg::cfg_t                   cfg,
    input  wire logic                       adv,
    input  gcf_pkg::win_t                   win,
    input  wire logic                       win_vld,
    input  wire logic                       win_last,
    output logic                            out_vld,
    output logic [gcf_pkg::PIX_W-1:0]       out_pixel,
    output logic                            out_last
);

    localparam int PW = gcf_pkg::PROD_W;
    localparam int RW = gcf_pkg::ROW_W;
    localparam int TW = gcf_pkg::TOT_W;

    logic [2:0][gcf_pkg::KROW_W-1:0] kern;

    logic signed [PW-1:0] prod_next [3][3];
    logic signed [PW-1:0] prod_reg  [3][3];
    logic signed [RW-1:0] rsum_next [3];
    logic signed [RW-1:0] rsum_reg  [3];
    logic signed [TW-1:0] total;
    logic [gcf_pkg::PIX_W-1:0] clamped;

    logic s3_vld_reg, s3_last_reg;
    logic s4_vld_reg, s4_last_reg;
    logic out_vld_reg, out_last_reg;
    logic [gcf_pkg::PIX_W-1:0] out_pixel_reg;

    assign kern[0] = cfg.kernel_row_top;
    assign kern[1] = cfg.kernel_row_middle;
    assign kern[2] = cfg.kernel_row_bottom;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = PW'(signed'({1'b0, win[r][c]}))
                                * PW'(gcf_pkg::coef(kern[r], c));
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rsum_next[r] = RW'(prod_reg[r][0]) + RW'(prod_reg[r][1]) + RW'(prod_reg[r][2]);
        end
    end

    always_comb
    begin
        total = TW'(rsum_reg[0]) + TW'(rsum_reg[1]) + TW'(rsum_reg[2]);
        if (total < 0)
            clamped = '0;
        else if (total > TW'(gcf_pkg::PIX_MAX))
            clamped = gcf_pkg::PIX_W'(gcf_pkg::PIX_MAX);
        else
            clamped = total[gcf_pkg::PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg  <= win_vld;
            s4_vld_reg  <= s3_vld_reg;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg      <= prod_next;
            rsum_reg      <= rsum_next;
            s3_last_reg   <= win_last;
            s4_last_reg   <= s3_last_reg;
            out_last_reg  <= s4_last_reg;
            out_pixel_reg <= clamped;
        end
    end

    assign out_vld   = out_vld_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

@@ design/gray_3x3_convolution_filter.sv @@
// Channel   Dir  Handshake            Payload
// pix       in   valid/ready          red, green, blue (8b each)
// res       out  valid/ready          filtered_pixel (8b), last_result
// apb       cfg  psel/penable/pready  paddr (5b), pwdata/prdata (32b)
//
// One pixel per clock while no result waits; each pixel passes the line RAM read, window,
// products, row sums and clamp into the output register before its result is valid.
// The line RAM is one 16-bit wide port pair: read at the pixel's column on accept,
// written back from the first stage as it advances. Whole pipeline holds while a result waits; pix
// ready is low only then. Reset clears positions, window and valid bits; no RAM pass.
`default_nettype none

module gray_3x3_convolution_filter #(
    parameter int MAX_WIDTH  = gcf_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = gcf_pkg::MAX_HEIGHT_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gcf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [gcf_pkg::DATA_W-1:0] pwdata,
    output logic      [gcf_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    gcf_pix_if.sink                         pix,
    gcf_res_if.source                       res
);

    gcf_pkg::cfg_t cfg;
    gcf_pkg::win_t win;
    logic          win_vld;
    logic          win_last;
    logic          adv;
    logic          in_acc;
    logic          out_vld;
    logic [gcf_pkg::PIX_W-1:0] out_pixel;
    logic          out_last;

    assign adv       = !out_vld || res.ready;
    assign pix.ready = adv;
    assign in_acc    = pix.valid && adv;

    gcf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gcf_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .adv      (adv),
        .in_acc   (in_acc),
        .red      (pix.red),
        .green    (pix.green),
        .blue     (pix.blue),
        .win      (win),
        .win_vld  (win_vld),
        .win_last (win_last)
    );

    gcf_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .adv       (adv),
        .win       (win),
        .win_vld   (win_vld),
        .win_last  (win_last),
        .out_vld   (out_vld),
        .out_pixel (out_pixel),
        .out_last  (out_last)
    );

    assign res.valid          = out_vld;
    assign res.filtered_pixel = out_pixel;
    assign res.last_result    = out_last;

endmodule

`default_nettype wire

@@ design/gcf_checker.sv @@
`default_nettype none

module gcf_protocol_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_ready,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [gcf_pkg::PIX_W-1:0]  out_pixel,
    input  wire logic                       out_last,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gcf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [gcf_pkg::DATA_W-1:0] pwdata,
    input  wire logic [gcf_pkg::DATA_W-1:0] prdata,
    input  wire logic                       pready
);

    // input side stalls exactly when a result sits untaken
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("pix ready does not track result backpressure");

    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_last))
        else $error("result payload changed while stalled");

    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready)
        && $past(paddr[4:2] == gcf_pkg::REG_IMAGE_WIDTH)
        && psel && !pwrite && paddr[4:2] == gcf_pkg::REG_IMAGE_WIDTH
        |-> prdata[gcf_pkg::SIZE_W-1:0] == $past(pwdata[gcf_pkg::SIZE_W-1:0]))
        else $error("image width readback mismatch");

endmodule

bind gray_3x3_convolution_filter gcf_protocol_checker u_gcf_protocol_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_pixel (res.filtered_pixel),
    .out_last  (res.last_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire

@@ verif/gcf_checker.sv @@
module gcf_checker
    import gcf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    gcf_pix_if                     pix,
    gcf_res_if                     res,
    output int                     fail_count,
    output int                     pending,
    output int                     result_count,
    output logic                   at_frame_start
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W       = MAX_WIDTH_DEFAULT;
    localparam int MAX_H       = MAX_HEIGHT_DEFAULT;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             last;
    } outcome_t;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [KROW_W-1:0] kernel_rows [3];
    logic [PIX_W-1:0]  older_line [MAX_W];
    logic [PIX_W-1:0]  newer_line [MAX_W];
    logic [PIX_W-1:0]  window [3][3];
    int                col_pos;
    int                row_pos;
    outcome_t          predicted_pixels [$];

    initial
    begin
        fail_count   = 0;
        result_count = 0;
    end

    function automatic int eff_size(input logic [SIZE_W-1:0] raw, input int limit);
        if (raw < MIN_SIZE)
            return MIN_SIZE;
        if (raw > limit)
            return limit;
        return int'(raw);
    endfunction

    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // one accepted pixel: shift the window, update the line stores, maybe emit a result
    function automatic void convolve_pixel(input logic [PIX_W-1:0] r, g, b);
        int       w;
        int       h;
        int       x;
        int       y;
        int       acc;
        int       coeff;
        outcome_t item;
        logic [PIX_W-1:0] gray;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, MAX_H);
        gray = PIX_W'((int'(r) + int'(g) + int'(b)) / 3);
        // positions left over from a size change wrap here
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        x = col_pos;
        y = row_pos;
        for (int i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = older_line[x];
        window[1][2] = newer_line[x];
        window[2][2] = gray;
        older_line[x] = newer_line[x];
        newer_line[x] = gray;
        if (x >= 2 && y >= 2)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    coeff = $signed(kernel_rows[i][PIX_W*j +: PIX_W]);
                    acc += int'(window[i][j]) * coeff;
                end
            if (acc < 0)
                acc = 0;
            if (acc > PIX_MAX)
                acc = PIX_MAX;
            item.level = PIX_W'(acc);
            item.last  = (x == w - 1) && (y == h - 1);
            predicted_pixels.push_back(item);
        end
        col_pos = x + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function automatic logic next_is_frame_start();
        int w;
        int h;
        int c;
        int r;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, MAX_H);
        c = col_pos;
        r = row_pos;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;
        return (c == 0) && (r == 0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            width_reg      = WIDTH_RESET;
            height_reg     = HEIGHT_RESET;
            kernel_rows[0] = KROW_TOP_RESET;
            kernel_rows[1] = KROW_MIDDLE_RESET;
            kernel_rows[2] = KROW_BOTTOM_RESET;
            foreach (older_line[i])
            begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            foreach (window[i, j])
                window[i][j] = '0;
            col_pos = 0;
            row_pos = 0;
            predicted_pixels.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_IMAGE_WIDTH:   width_reg      = pwdata[SIZE_W-1:0];
                    REG_IMAGE_HEIGHT:  height_reg     = pwdata[SIZE_W-1:0];
                    REG_KERNEL_TOP:    kernel_rows[0] = pwdata[KROW_W-1:0];
                    REG_KERNEL_MIDDLE: kernel_rows[1] = pwdata[KROW_W-1:0];
                    REG_KERNEL_BOTTOM: kernel_rows[2] = pwdata[KROW_W-1:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                convolve_pixel(pix.red, pix.green, pix.blue);
            if (res.valid && res.ready)
            begin
                result_count++;
                got.level = res.filtered_pixel;
                got.last  = res.last_result;
                if (predicted_pixels.size() == 0)
                    log_failure($sformatf("result %0d unexpected: pixel %0d last %0b",
                                          result_count, got.level, got.last));
                else
                begin
                    want = predicted_pixels.pop_front();
                    if (got.level !== want.level || got.last !== want.last)
                        log_failure($sformatf(
                            "result %0d mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                            result_count, want.level, want.last, got.level, got.last));
                end
            end
        end
        pending        = predicted_pixels.size();
        at_frame_start = next_is_frame_start();
    end

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcf_pkg::*;

    localparam int DRAIN_CYCLES = 8;   // pipeline depth plus margin
    localparam int REG_COUNT    = 5;
    localparam int RANDOM_PIXELS = 300;

    localparam logic [3*PIX_W-1:0] TEST_CARD [16] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
        24'h804020, 24'h010203, 24'hFEFDFC, 24'hFFFFFF
    };

    typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int          fail_count;
    int          pending;
    int          result_count;
    logic        at_frame_start;
    int          pixel_total = 0;
    int          reg_writes  = 0;
    int          burst_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_left  = 0;

    gcf_pix_if pix_bus ();
    gcf_res_if res_bus ();

    gray_3x3_convolution_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_bus),
        .res     (res_bus)
    );

    gcf_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pix            (pix_bus),
        .res            (res_bus),
        .fail_count     (fail_count),
        .pending        (pending),
        .result_count   (result_count),
        .at_frame_start (at_frame_start)
    );

    always #6 clk = ~clk;

    // receiver back-pressure, switching between stall patterns
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  res_bus.ready <= 1'b1;
            STALL_COIN:  res_bus.ready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: res_bus.ready <= ($urandom_range(0, 3) == 0);
            default:     res_bus.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial
    begin
        #6ms;
        $display("Some tests failed");
        $finish;
    end

    // all tasks below are entered and left at a falling edge

    task automatic apb_write(input int idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    task automatic push_pixel(input logic [3*PIX_W-1:0] rgb);
        pix_bus.valid <= 1'b1;
        pix_bus.red   <= rgb[23:16];
        pix_bus.green <= rgb[15:8];
        pix_bus.blue  <= rgb[7:0];
        do @(posedge clk); while (!pix_bus.ready);
        @(negedge clk);
        pixel_total++;
    endtask

    task automatic idle_pixels(input int n);
        repeat (n)
        begin
            pix_bus.valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        pix_bus.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // pixels at the first two columns or rows give no result, so let the pipeline empty too
    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] shade();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [3*PIX_W-1:0] rgb);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 24) == 0)
                wait_drained();
            else
                idle_pixels($urandom_range(0, 5));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        push_pixel(rgb);
    endtask

    task automatic next_pixel();
        send_pixel({shade(), shade(), shade()});
    endtask

    task automatic feed(input int n);
        repeat (n) next_pixel();
    endtask

    task automatic feed_frame();
        do next_pixel(); while (!at_frame_start);
    endtask

    task automatic complete_frame();
        while (!at_frame_start) next_pixel();
    endtask

    task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input logic [KROW_W-1:0] k_top, input logic [KROW_W-1:0] k_mid,
                             input logic [KROW_W-1:0] k_bot);
        settle();
        // junk above each field checks that only the register bits count
        apb_write(REG_IMAGE_WIDTH,   {21'($urandom), w});
        apb_write(REG_IMAGE_HEIGHT,  {21'($urandom), h});
        apb_write(REG_KERNEL_TOP,    {8'($urandom), k_top});
        apb_write(REG_KERNEL_MIDDLE, {8'($urandom), k_mid});
        apb_write(REG_KERNEL_BOTTOM, {8'($urandom), k_bot});
    endtask

    function automatic logic [KROW_W-1:0] pick_kernel_row();
        case ($urandom_range(0, 5))
            0:       return 24'h7F7F7F;
            1:       return 24'h808080;
            2:       return 24'hFF04FF;
            default: return KROW_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int               random_start;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pix_bus.valid = 1'b0;
        pix_bus.red   = '0;
        pix_bus.green = '0;
        pix_bus.blue  = '0;
        res_bus.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // writes past the register list must leave the reset kernel and size alone
        for (int i = REG_COUNT; i < 8; i++)
            apb_write(i, $urandom);

        // reset setup: 4x4 Laplacian over a test card of extremes
        foreach (TEST_CARD[i])
            send_pixel(TEST_CARD[i]);

        // undersized width and height both act as 3; all-ones kernel saturates
        configure(11'd0, 11'd1, 24'h010101, 24'h010101, 24'h010101);
        feed_frame();

        // width shrinks in the middle of a row: column wraps into the next row
        configure(11'd9, 11'd5, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
        feed(24);
        settle();
        apb_write(REG_IMAGE_WIDTH, 32'd5);
        complete_frame();

        // oversized height, then shrunk past the current row mid-image; identity kernel
        configure(11'd3, 11'h7FF, 24'h000000, 24'h000100, 24'h000000);
        feed(16);
        settle();
        apb_write(REG_IMAGE_HEIGHT, 32'd4);
        complete_frame();

        // oversized width clamps to the widest line: a long first row that does not wrap,
        // then a narrow width finishes the image
        configure(11'h7FF, 11'd3, 24'h7F7F7F, KROW_W'($urandom), 24'h808080);
        feed(20);
        settle();
        apb_write(REG_IMAGE_WIDTH, 32'd5);
        complete_frame();

        random_start = pixel_total;
        while (pixel_total - random_start < RANDOM_PIXELS)
        begin
            w = ($urandom_range(0, 5) == 0) ? SIZE_W'($urandom_range(0, 2))
                                            : SIZE_W'($urandom_range(3, 12));
            h = ($urandom_range(0, 5) == 0) ? SIZE_W'($urandom_range(0, 2))
                                            : SIZE_W'($urandom_range(3, 7));
            configure(w, h, pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
            repeat ($urandom_range(1, 3)) feed_frame();
        end

        settle();
        $display("Covered %0d pixels and %0d register writes: sizes from 3x3 to a clamped",
                 pixel_total, reg_writes);
        $display("1024-wide line, mid-image size changes; %0d filtered results compared.",
                 result_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
